### src/vbe_pkg.sv
package vbe_pkg;

   localparam int unsigned GROUP_BITS = 7;
   localparam int unsigned NUM_GROUPS = 10;
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned DATA_W     = GROUP_BITS * NUM_GROUPS;
   localparam int unsigned PAD_W      = DATA_W - VALUE_W;
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned BYTE_W     = 8;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(NUM_GROUPS);
   localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_NORM = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // commands from the sequencer to the shift unit
   typedef struct packed {
      logic load;
      logic norm_step;
      logic emit_step;
   } shift_cmd_type;

   // status from the shift unit back to the sequencer
   typedef struct packed {
      logic top_zero;
      logic can_drop;
      logic remain_one;
   } shift_stat_type;

endpackage

### src/vbe_req_if.sv
interface vbe_req_if;
   import vbe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [VALUE_W-1:0]   value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

### src/vbe_rsp_if.sv
interface vbe_rsp_if;
   import vbe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    out_byte;
   logic                 last;
   logic [COUNT_W-1:0]   group_count;

   modport source (output valid, output out_byte, output last, output group_count,
                   input ready);
   modport sink   (input valid, input out_byte, input last, input group_count,
                   output ready);
endinterface

### src/vbe_mapper.sv
module vbe_mapper (
   input  logic                          is_signed,
   input  logic [vbe_pkg::VALUE_W-1:0]   value,
   output logic [vbe_pkg::VALUE_W-1:0]   mapped
);
   import vbe_pkg::*;

   logic                 neg;
   logic [VALUE_W-1:0]   mag;

   // zigzag style map: magnitude shifted up, sign in bit 0, wraps mod 2^64
   always_comb begin
      neg = value[VALUE_W-1];
      mag = neg ? (~value + VALUE_W'(1)) : value;
      if (is_signed) begin
         mapped = {mag[VALUE_W-2:0], neg};
      end else begin
         mapped = value;
      end
   end
endmodule

### src/vbe_shifter.sv
module vbe_shifter (
   input  logic                            clock,
   input  logic                            reset,
   input  vbe_pkg::shift_cmd_type          cmd,
   input  logic [vbe_pkg::VALUE_W-1:0]     load_value,
   output vbe_pkg::shift_stat_type         stat,
   output logic [vbe_pkg::GROUP_BITS-1:0]  top_group,
   output logic [vbe_pkg::COUNT_W-1:0]     total
);
   import vbe_pkg::*;

   logic [DATA_W-1:0]    data_ff, data_in;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic [COUNT_W-1:0]   remain_ff, remain_in;

   // one 7-bit left shift, shared by normalizing and emitting
   always_comb begin
      data_in   = data_ff;
      total_in  = total_ff;
      remain_in = remain_ff;
      if (cmd.load) begin
         data_in   = {{PAD_W{1'b0}}, load_value};
         total_in  = COUNT_FULL;
         remain_in = COUNT_FULL;
      end else if (cmd.norm_step) begin
         data_in   = {data_ff[DATA_W-GROUP_BITS-1:0], {GROUP_BITS{1'b0}}};
         total_in  = total_ff - COUNT_ONE;
         remain_in = remain_ff - COUNT_ONE;
      end else if (cmd.emit_step) begin
         data_in   = {data_ff[DATA_W-GROUP_BITS-1:0], {GROUP_BITS{1'b0}}};
         remain_in = remain_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         total_ff  <= COUNT_FULL;
         remain_ff <= COUNT_FULL;
      end else begin
         total_ff  <= total_in;
         remain_ff <= remain_in;
      end
   end

   assign top_group       = data_ff[DATA_W-1 -: GROUP_BITS];
   assign total           = total_ff;
   assign stat.top_zero   = (top_group == '0);
   assign stat.can_drop   = (total_ff != COUNT_ONE);
   assign stat.remain_one = (remain_ff == COUNT_ONE);
endmodule

### src/vbe_sequencer.sv
module vbe_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  vbe_pkg::shift_stat_type   stat,
   output vbe_pkg::shift_cmd_type    cmd
);
   import vbe_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // drop leading zero groups, always keep at least one
            if (stat.top_zero && stat.can_drop) begin
               cmd.norm_step = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_step = 1'b1;
               if (stat.remain_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### src/varint_byte_encoder.sv
// varint byte encoder: 64-bit value in, 7-bit groups out, most significant first
// req_if carries req_type (1 = signed, sign and magnitude mapped first) and value;
// it transfers when valid and ready are both high. rsp_if carries one byte per
// transfer: out_byte (bit 7 set on the final byte), last and group_count.
// an item with n groups (1 to 10) is loaded on its input transfer; then a single
// 70-bit shift unit drops leading zero groups, one group per cycle, and the n
// bytes go out from the same shifter, one per cycle while the receiver is ready.
// req_if.ready is high only while the block is idle, so one item is in work
// at a time.
// when the receiver stalls, the current byte is held steady and the shifter
// waits; nothing is lost.
// synchronous reset returns the sequencer to idle and drops any item in work;
// req_if.ready is high from the first cycle after reset.
module varint_byte_encoder (
   input  logic         clock,
   input  logic         reset,
   vbe_req_if.sink      req_if,
   vbe_rsp_if.source    rsp_if
);
   import vbe_pkg::*;

   logic [VALUE_W-1:0]      mapped;
   shift_cmd_type           cmd;
   shift_stat_type          stat;
   logic [GROUP_BITS-1:0]   top_group;
   logic [COUNT_W-1:0]      total;

   vbe_mapper u_mapper (
      .is_signed (req_if.req_type),
      .value     (req_if.value),
      .mapped    (mapped)
   );

   vbe_shifter u_shifter (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_value (mapped),
      .stat       (stat),
      .top_group  (top_group),
      .total      (total)
   );

   vbe_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign rsp_if.out_byte    = {stat.remain_one, top_group};
   assign rsp_if.last        = stat.remain_one;
   assign rsp_if.group_count = total;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.group_count != '0 && rsp_if.group_count <= COUNT_FULL))
      else $error("group count out of range");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !rsp_if.valid)
      else $error("input taken while a byte is pending");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last) |=> req_if.ready)
      else $error("not idle after final byte");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=>
      (rsp_if.valid && $stable(rsp_if.out_byte) && $stable(rsp_if.group_count)))
      else $error("byte changed while stalled");
`endif
endmodule

### dv/varint_byte_encoder_tb.sv
`timescale 1ns / 100ps

module varint_byte_encoder_tb;
   import vbe_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int ITEMS_PER_PHASE = 47;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam logic [BYTE_W-1:0]     STOP_BIT   = 8'h80;
   localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'h7f;
   localparam logic REQ_UNSIGNED = 1'b0;
   localparam logic REQ_SIGNED   = 1'b1;

   // expected byte stream for every accepted value, oldest first
   class varint_scoreboard;
      typedef struct packed {
         logic [BYTE_W-1:0]  out_byte;
         logic               last;
         logic [COUNT_W-1:0] group_count;
      } coded_byte_type;

      coded_byte_type expected_q[$];
      int errors = 0;

      function void note_value(logic req_type, logic [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] mag;
         logic [VALUE_W-1:0] mapped;
         logic [VALUE_W-1:0] rest;
         int n;
         int grp;
         coded_byte_type cb;
         mapped = value;
         if (req_type == REQ_SIGNED) begin
            mag    = value[VALUE_W-1] ? -value : value;
            mapped = {mag[VALUE_W-2:0], value[VALUE_W-1]};
         end
         n    = 1;
         rest = mapped >> GROUP_BITS;
         while (rest != '0) begin
            n++;
            rest = rest >> GROUP_BITS;
         end
         for (int k = 0; k < n; k++) begin
            grp = n - 1 - k;
            cb.out_byte    = {1'b0, GROUP_MASK & GROUP_BITS'(mapped >> (grp * GROUP_BITS))};
            cb.last        = (grp == 0);
            if (cb.last)
               cb.out_byte = cb.out_byte | STOP_BIT;
            cb.group_count = COUNT_W'(n);
            expected_q.push_back(cb);
         end
      endfunction

      function void check_byte(logic [BYTE_W-1:0] out_byte, logic last,
                               logic [COUNT_W-1:0] group_count);
         coded_byte_type cb;
         if (expected_q.size() == 0) begin
            $error("unexpected byte transfer: out_byte %h last %b group_count %0d",
                   out_byte, last, group_count);
            errors++;
            return;
         end
         cb = expected_q.pop_front();
         if (out_byte !== cb.out_byte) begin
            $error("out_byte: expected %h, got %h", cb.out_byte, out_byte);
            errors++;
         end
         if (last !== cb.last) begin
            $error("last: expected %b, got %b", cb.last, last);
            errors++;
         end
         if (group_count !== cb.group_count) begin
            $error("group_count: expected %0d, got %0d", cb.group_count, group_count);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count    = 0;
   int   src_idle_pct   = 0;
   int   sink_stall_pct = 0;
   int   hold_left      = 0;

   varint_scoreboard board = new();

   vbe_req_if req_ch ();
   vbe_rsp_if rsp_ch ();

   varint_byte_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("varint_byte_encoder_tb: done, errors");
         $finish;
      end
   end

   // offer one value, with random idle cycles ahead of it
   task automatic send_value(input logic req_type, input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= req_type;
      req_ch.value    <= value;
      do
         @(posedge clock);
      while (!req_ch.ready);
      board.note_value(req_type, value);
   endtask

   // random width so that every group count shows up, now and then full width
   function automatic logic [VALUE_W-1:0] rand_value();
      logic [VALUE_W-1:0] raw;
      int width;
      raw   = {$urandom, $urandom};
      width = $urandom_range(VALUE_W, 0);
      if ($urandom_range(7) != 0 && width < VALUE_W)
         raw = raw & ((64'd1 << width) - 64'd1);
      return raw;
   endfunction

   task automatic send_random(input int count);
      logic req_type;
      logic [VALUE_W-1:0] value;
      for (int i = 0; i < count; i++) begin
         req_type = 1'($urandom_range(1));
         value    = rand_value();
         if (req_type == REQ_SIGNED && $urandom_range(1) == 1)
            value = -value;
         send_value(req_type, value);
      end
   endtask

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      wait (reset === 1'b0);
      forever begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_byte(rsp_ch.out_byte, rsp_ch.last, rsp_ch.group_count);
      end
   end

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = 1'b0;
      req_ch.value    = '0;
      rsp_ch.ready    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // group boundaries and extremes
      send_value(REQ_UNSIGNED, 64'd0);
      send_value(REQ_UNSIGNED, 64'd1);
      send_value(REQ_UNSIGNED, 64'h7f);
      send_value(REQ_UNSIGNED, 64'h80);
      send_value(REQ_UNSIGNED, 64'h3fff);
      send_value(REQ_UNSIGNED, 64'h4000);
      send_value(REQ_UNSIGNED, 64'h00ff_ffff_ffff_ffff);
      send_value(REQ_UNSIGNED, 64'h0100_0000_0000_0000);
      send_value(REQ_UNSIGNED, 64'h7fff_ffff_ffff_ffff);
      send_value(REQ_UNSIGNED, 64'h8000_0000_0000_0000);
      send_value(REQ_UNSIGNED, 64'hffff_ffff_ffff_ffff);
      send_value(REQ_UNSIGNED, 64'haaaa_aaaa_aaaa_aaaa);
      send_value(REQ_UNSIGNED, 64'h5555_5555_5555_5555);
      send_value(REQ_SIGNED, 64'd0);
      send_value(REQ_SIGNED, 64'd1);
      send_value(REQ_SIGNED, 64'hffff_ffff_ffff_ffff);
      send_value(REQ_SIGNED, 64'd63);
      send_value(REQ_SIGNED, 64'd64);
      send_value(REQ_SIGNED, -64'd64);
      send_value(REQ_SIGNED, -64'd65);
      // most negative wraps to a single byte
      send_value(REQ_SIGNED, 64'h8000_0000_0000_0000);
      send_value(REQ_SIGNED, 64'h7fff_ffff_ffff_ffff);
      send_value(REQ_SIGNED, 64'h8000_0000_0000_0001);

      // no idling, starting with a long receiver hold-off to back up the input
      hold_left = HOLD_CYCLES;
      send_random(ITEMS_PER_PHASE);

      src_idle_pct   = 82;
      sink_stall_pct = 0;
      send_random(ITEMS_PER_PHASE);

      src_idle_pct   = 0;
      sink_stall_pct = 82;
      send_random(ITEMS_PER_PHASE);

      src_idle_pct   = 21;
      sink_stall_pct = 21;
      send_random(ITEMS_PER_PHASE);

      req_ch.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0)
         $display("varint_byte_encoder_tb: done, clean");
      else
         $display("varint_byte_encoder_tb: done, errors");
      $finish;
   end

endmodule
